### rtl/nvrs_pkg.sv
// Shared types, constants and helpers for the NV12 resize-to-RGB block.
// No dependencies; used by nv12_resize_to_rgb.
package nvrs_pkg;

  localparam int MAX_STRIDE     = 1024;
  localparam int MAX_HEIGHT     = 1024;
  localparam int MAX_OUT_DIM    = 4096;
  localparam int COEF_FRAC_BITS = 10;

  localparam int LUMA_DEPTH   = MAX_STRIDE * MAX_HEIGHT;
  localparam int CHROMA_DEPTH = LUMA_DEPTH / 2;
  localparam int BANK_DEPTH   = CHROMA_DEPTH / 2;
  localparam int LUMA_AW      = $clog2(LUMA_DEPTH);
  localparam int CHROMA_AW    = $clog2(CHROMA_DEPTH);
  localparam int BANK_AW      = $clog2(BANK_DEPTH);

  localparam int QW    = $clog2(MAX_STRIDE);
  localparam int NUM_W = 23;
  localparam int REM_W = 13;
  localparam int SUM_W = 21;
  localparam int LAT   = 16;

  localparam int COEF_Y  = (1164 * (1 << COEF_FRAC_BITS) + 500) / 1000;
  localparam int COEF_RV = (1596 * (1 << COEF_FRAC_BITS) + 500) / 1000;
  localparam int COEF_GU = (392 * (1 << COEF_FRAC_BITS) + 500) / 1000;
  localparam int COEF_GV = (813 * (1 << COEF_FRAC_BITS) + 500) / 1000;
  localparam int COEF_BU = (2017 * (1 << COEF_FRAC_BITS) + 500) / 1000;

  typedef enum logic [1:0] {
    OP_LUMA    = 2'd0,
    OP_CHROMA  = 2'd1,
    OP_CONVERT = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_SIZE  = 3'd1,
    ST_MISSING   = 3'd2,
    ST_BAD_STRIDE = 3'd3,
    ST_TRUNCATED = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    REG_SRC_WIDTH  = 3'd0,
    REG_SRC_HEIGHT = 3'd1,
    REG_SRC_STRIDE = 3'd2,
    REG_OUT_WIDTH  = 3'd3,
    REG_OUT_HEIGHT = 3'd4,
    REG_LUMA_LEN   = 3'd5,
    REG_CHROMA_LEN = 3'd6,
    REG_UNUSED     = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [19:0] address;
    logic [7:0]  byte_value;
    logic [11:0] out_x;
    logic [11:0] out_y;
  } in_word_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [2:0] status;
  } out_word_t;

  typedef struct packed {
    logic        v;
    op_t         op;
    logic [19:0] addr;
    logic [7:0]  bv;
    status_t     st;
  } ctl_t;

  typedef struct packed {
    ctl_t             c;
    logic             cx;
    logic             cy;
    logic [QW-1:0]    nx;
    logic [QW-1:0]    ny;
    logic [REM_W-1:0] rx;
    logic [REM_W-1:0] ry;
    logic [QW-1:0]    qx;
    logic [QW-1:0]    qy;
  } div_t;

  function automatic logic [7:0] to_byte(input logic signed [SUM_W-1:0] s);
    logic [SUM_W-1:0] q;
    q = $unsigned(s) >> COEF_FRAC_BITS;
    if (s < 0) begin
      return 8'd0;
    end else if (q > SUM_W'(255)) begin
      return 8'd255;
    end else begin
      return q[7:0];
    end
  endfunction

endpackage

### rtl/nvrs_ram.sv
// Generic single-port RAM with a registered read.
// No dependencies.
module nvrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

### rtl/nv12_resize_to_rgb.sv
// Top level of the NV12 frame store with nearest-neighbor scaling and RGB conversion.
// Depends on nvrs_pkg and nvrs_ram.
//
// Usage: an input word on req is accepted when start is high and busy is low.
// busy stays low, so a word may be issued every cycle. Op 0 and op 1 write a
// byte into the luma or chroma store; op 2 requests one output pixel; op 3 is
// dropped. Each pixel request yields one result word on rsp, marked by done
// for one cycle, in request order. Writes give no result. The receiver cannot
// stall; results must be taken when shown. Throughput is one word per cycle:
// the coordinate divide is a 10-stage pipeline with one quotient bit per stage,
// and each store is a single-port RAM that reads or writes once per cycle.
// Writes and pixel reads use the RAMs in the same pipeline stage, so a pixel
// read sees every earlier write. Registers must be written over the APB port
// only while no request is in flight; the block itself does not enforce this.
// Reset clears the registers to their defaults and empties the pipeline; the
// stores are not cleared and hold garbage until written.
module nv12_resize_to_rgb
  import nvrs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  in_word_t    req,
  output logic        done,
  output out_word_t   rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [10:0] src_width, src_height, src_stride;
  logic [12:0] out_width, out_height;
  logic [20:0] luma_length;
  logic [19:0] chroma_length;
  reg_idx_t    ridx;

  assign ridx   = reg_idx_t'(paddr[4:2]);
  assign pready = 1'b1;
  assign busy   = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width     <= '0;
      src_height    <= '0;
      src_stride    <= '0;
      out_width     <= 13'd1;
      out_height    <= 13'd1;
      luma_length   <= '0;
      chroma_length <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (ridx)
        REG_SRC_WIDTH:  src_width     <= pwdata[10:0];
        REG_SRC_HEIGHT: src_height    <= pwdata[10:0];
        REG_SRC_STRIDE: src_stride    <= pwdata[10:0];
        REG_OUT_WIDTH:  out_width     <= pwdata[12:0];
        REG_OUT_HEIGHT: out_height    <= pwdata[12:0];
        REG_LUMA_LEN:   luma_length   <= pwdata[20:0];
        REG_CHROMA_LEN: chroma_length <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_SRC_WIDTH:  prdata = 32'(src_width);
      REG_SRC_HEIGHT: prdata = 32'(src_height);
      REG_SRC_STRIDE: prdata = 32'(src_stride);
      REG_OUT_WIDTH:  prdata = 32'(out_width);
      REG_OUT_HEIGHT: prdata = 32'(out_height);
      REG_LUMA_LEN:   prdata = 32'(luma_length);
      REG_CHROMA_LEN: prdata = 32'(chroma_length);
      default:        prdata = 32'd0;
    endcase
  end

  // Status checks that depend on the registers alone.
  status_t          cfg_st;
  logic [NUM_W-1:0] px, py;

  always_comb begin
    if (src_width == 0 || src_height == 0 || src_height > 11'(MAX_HEIGHT) ||
        out_width == 0 || out_height == 0 ||
        out_width > 13'(MAX_OUT_DIM) || out_height > 13'(MAX_OUT_DIM)) begin
      cfg_st = ST_BAD_SIZE;
    end else if (luma_length == 0 || chroma_length == 0) begin
      cfg_st = ST_MISSING;
    end else if (src_stride < src_width || src_stride > 11'(MAX_STRIDE)) begin
      cfg_st = ST_BAD_STRIDE;
    end else begin
      cfg_st = ST_OK;
    end
  end

  assign px = NUM_W'(req.out_x * src_width);
  assign py = NUM_W'(req.out_y * src_height);

  // Divider pipeline: d[0] holds the products, each later stage one quotient bit.
  div_t d [QW+1];
  div_t dn [QW];

  always_comb begin
    for (int k = 0; k < QW; k++) begin
      logic [REM_W:0] tx, ty;
      tx = {d[k].rx, d[k].nx[QW-1-k]};
      ty = {d[k].ry, d[k].ny[QW-1-k]};
      dn[k] = d[k];
      if (tx >= {1'b0, out_width}) begin
        dn[k].rx = REM_W'(tx - {1'b0, out_width});
        dn[k].qx = {d[k].qx[QW-2:0], 1'b1};
      end else begin
        dn[k].rx = tx[REM_W-1:0];
        dn[k].qx = {d[k].qx[QW-2:0], 1'b0};
      end
      if (ty >= {1'b0, out_height}) begin
        dn[k].ry = REM_W'(ty - {1'b0, out_height});
        dn[k].qy = {d[k].qy[QW-2:0], 1'b1};
      end else begin
        dn[k].ry = ty[REM_W-1:0];
        dn[k].qy = {d[k].qy[QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= QW; k++) begin
        d[k].c.v <= 1'b0;
      end
    end else begin
      d[0].c.v <= start && !busy && req.op != OP_NONE;
      for (int k = 0; k < QW; k++) begin
        d[k+1].c.v <= d[k].c.v;
      end
    end
    d[0].c.op   <= op_t'(req.op);
    d[0].c.addr <= req.address;
    d[0].c.bv   <= req.byte_value;
    d[0].c.st   <= cfg_st;
    d[0].cx     <= {1'b0, req.out_x} >= out_width;
    d[0].cy     <= {1'b0, req.out_y} >= out_height;
    d[0].nx     <= px[QW-1:0];
    d[0].ny     <= py[QW-1:0];
    d[0].rx     <= px[NUM_W-1:QW];
    d[0].ry     <= py[NUM_W-1:QW];
    d[0].qx     <= '0;
    d[0].qy     <= '0;
    for (int k = 0; k < QW; k++) begin
      d[k+1].c.op   <= dn[k].c.op;
      d[k+1].c.addr <= dn[k].c.addr;
      d[k+1].c.bv   <= dn[k].c.bv;
      d[k+1].c.st   <= dn[k].c.st;
      d[k+1].cx     <= dn[k].cx;
      d[k+1].cy     <= dn[k].cy;
      d[k+1].nx     <= dn[k].nx;
      d[k+1].ny     <= dn[k].ny;
      d[k+1].rx     <= dn[k].rx;
      d[k+1].ry     <= dn[k].ry;
      d[k+1].qx     <= dn[k].qx;
      d[k+1].qy     <= dn[k].qy;
    end
  end

  // Source coordinates and row offsets.
  logic [QW-1:0] x0, y0;
  ctl_t          e_c;
  logic [QW-1:0] e_x0;
  logic [19:0]   e_lrow;
  logic [18:0]   e_crow;

  assign x0 = d[QW].cx ? QW'(src_width - 11'd1) : d[QW].qx;
  assign y0 = d[QW].cy ? QW'(src_height - 11'd1) : d[QW].qy;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_c.v <= 1'b0;
    end else begin
      e_c.v <= d[QW].c.v;
    end
    e_c.op   <= d[QW].c.op;
    e_c.addr <= d[QW].c.addr;
    e_c.bv   <= d[QW].c.bv;
    e_c.st   <= d[QW].c.st;
    e_x0     <= x0;
    e_lrow   <= 20'(y0 * src_stride);
    e_crow   <= 19'(y0[QW-1:1] * src_stride);
  end

  // Store addresses; writes and pixel reads share this stage.
  logic [LUMA_AW-1:0]   li;
  logic [CHROMA_AW-1:0] uvi;
  logic                 trunc;
  logic                 f_conv, f_odd;
  status_t              f_st;
  logic                 f_lwe, f_we0, f_we1;
  logic [LUMA_AW-1:0]   f_la;
  logic [BANK_AW-1:0]   f_a0, f_a1;
  logic [7:0]           f_bv;

  assign li    = e_lrow + LUMA_AW'(e_x0);
  assign uvi   = e_crow + CHROMA_AW'({e_x0[QW-1:1], 1'b0});
  assign trunc = 20'(uvi) + 20'd1 >= chroma_length ||
                 20'(uvi) + 20'd1 >= 20'(CHROMA_DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      f_conv <= 1'b0;
      f_lwe  <= 1'b0;
      f_we0  <= 1'b0;
      f_we1  <= 1'b0;
    end else begin
      f_conv <= e_c.v && e_c.op == OP_CONVERT;
      f_lwe  <= e_c.v && e_c.op == OP_LUMA;
      f_we0  <= e_c.v && e_c.op == OP_CHROMA && !e_c.addr[19] && !e_c.addr[0];
      f_we1  <= e_c.v && e_c.op == OP_CHROMA && !e_c.addr[19] && e_c.addr[0];
    end
    f_st <= (e_c.st == ST_OK && trunc) ? ST_TRUNCATED : e_c.st;
    f_bv <= e_c.bv;
    if (e_c.op == OP_CONVERT) begin
      f_la  <= li;
      f_odd <= uvi[0];
      f_a0  <= uvi[0] ? BANK_AW'(uvi[CHROMA_AW-1:1] + 1'b1) : uvi[CHROMA_AW-1:1];
      f_a1  <= uvi[CHROMA_AW-1:1];
    end else begin
      f_la  <= e_c.addr;
      f_odd <= 1'b0;
      f_a0  <= e_c.addr[BANK_AW:1];
      f_a1  <= e_c.addr[BANK_AW:1];
    end
  end

  logic [7:0] ly, cb0, cb1;

  nvrs_ram #(.WIDTH(8), .DEPTH(LUMA_DEPTH)) u_luma (
    .clk(clk), .we(f_lwe), .addr(f_la), .wdata(f_bv), .rdata(ly)
  );
  nvrs_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_chroma_even (
    .clk(clk), .we(f_we0), .addr(f_a0), .wdata(f_bv), .rdata(cb0)
  );
  nvrs_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_chroma_odd (
    .clk(clk), .we(f_we1), .addr(f_a1), .wdata(f_bv), .rdata(cb1)
  );

  logic    g_v, g_odd;
  status_t g_st;

  always_ff @(posedge clk) begin
    if (rst) begin
      g_v <= 1'b0;
    end else begin
      g_v <= f_conv;
    end
    g_st  <= f_st;
    g_odd <= f_odd;
  end

  // Color conversion.
  logic [7:0]        cy, ucode, vcode;
  logic signed [8:0] cs;
  logic signed [7:0] us, vs;

  assign cy    = (ly > 8'd16) ? 8'(ly - 8'd16) : 8'd0;
  assign ucode = g_odd ? cb1 : cb0;
  assign vcode = g_odd ? cb0 : cb1;
  assign cs    = $signed({1'b0, cy});
  assign us    = $signed({~ucode[7], ucode[6:0]});
  assign vs    = $signed({~vcode[7], vcode[6:0]});

  logic                    h_v;
  status_t                 h_st;
  logic signed [SUM_W-1:0] sr, sg, sb;

  always_ff @(posedge clk) begin
    if (rst) begin
      h_v <= 1'b0;
    end else begin
      h_v <= g_v;
    end
    h_st <= g_st;
    sr   <= SUM_W'(COEF_Y * cs + COEF_RV * vs);
    sg   <= SUM_W'(COEF_Y * cs - COEF_GU * us - COEF_GV * vs);
    sb   <= SUM_W'(COEF_Y * cs + COEF_BU * us);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= h_v;
    end
    rsp.status <= h_st;
    if (h_st == ST_OK) begin
      rsp.red   <= to_byte(sr);
      rsp.green <= to_byte(sg);
      rsp.blue  <= to_byte(sb);
    end else begin
      rsp.red   <= 8'd0;
      rsp.green <= 8'd0;
      rsp.blue  <= 8'd0;
    end
  end

  a_conv_result: assert property (@(posedge clk) disable iff (rst)
    start && !busy && req.op == OP_CONVERT |-> ##LAT done)
    else $error("pixel request produced no result word");

  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    start && !busy && req.op != OP_CONVERT |-> ##LAT !done)
    else $error("write word produced a result word");

  a_error_black: assert property (@(posedge clk) disable iff (rst)
    done && rsp.status != ST_OK |-> rsp.red == 0 && rsp.green == 0 && rsp.blue == 0)
    else $error("error result carries nonzero color");

  a_ok_stride: assert property (@(posedge clk) disable iff (rst)
    done && rsp.status == ST_OK |-> src_stride >= src_width && luma_length != 0)
    else $error("result marked ok under an invalid setup");

endmodule
